>>> rtl/ipsp_pkg.sv
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants for the IPS patch stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_BADHDR = 2'd3;

  localparam int ADDR_W = 25;
  localparam int LEN_W  = 16;
  localparam int OFS_W  = 24;

  // Offset value that ends the stream ("EOF")
  localparam logic [OFS_W-1:0] EOF_MARK = 24'h454F46;
  localparam int               HDR_LEN  = 5;

  // One result word from the parser
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [7:0]        value;
  } ipsp_result_t;

  // Expected header text "PATCH"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h50;  // P
      3'd1:    c = 8'h41;  // A
      3'd2:    c = 8'h54;  // T
      3'd3:    c = 8'h43;  // C
      3'd4:    c = 8'h48;  // H
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ips_patch_stream_parser_top.sv
// ----------------------------------------------------------------------------
// ips_patch_stream_parser_top
// IPS patch stream parser: bytes in, write and fill commands and status words out.
// ----------------------------------------------------------------------------
// Accepts one patch byte per cycle while in_stall is low. The byte is
// captured in an input register and decoded there against the parser state,
// and any command then lands in the result register, where the command word
// is held while out_stall is high. The input register and the result
// register set this one-word-per-cycle rate while out_stall is low; a byte
// that yields no command simply updates the parser state. After an end
// marker or a bad header word all further bytes are accepted and dropped.
// There is no start-up sweep: the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_patch_stream_parser_top import ipsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        patch_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [ADDR_W-1:0]      target_address,
  output logic [LEN_W-1:0]       run_length,
  output logic [7:0]             fill_value
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         out_free;
  logic         step;
  ipsp_result_t res;

  // Input register
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= patch_byte;
    end
  end

  ipsp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (s1_byte),
    .res     (res)
  );

  ipsp_out_reg u_out (
    .clk            (clk),
    .rst            (rst),
    .res            (res),
    .stall          (out_stall),
    .free           (out_free),
    .valid          (out_valid),
    .kind           (kind),
    .target_address (target_address),
    .run_length     (run_length),
    .fill_value     (fill_value)
  );

  // Checks
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("output or input register valid after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled without a held word");

  a_write_len_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_WRITE |-> run_length == LEN_W'(1))
    else $error("write word with length other than one");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_END || kind == KIND_BADHDR)
    |-> target_address == '0 && run_length == '0 && fill_value == '0)
    else $error("status word carries payload");

  a_no_silent_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held result lost while stalled");

endmodule

`default_nettype wire

>>> rtl/ipsp_parser.sv
// ----------------------------------------------------------------------------
// ipsp_parser
// Record parser state and combinational decode of one patch byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_parser import ipsp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   byte_in,
  output ipsp_result_t      res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OFFSET,
    PH_SIZE,
    PH_DATA,
    PH_RUNCOUNT,
    PH_RUNVALUE,
    PH_ENDED,
    PH_ERROR
  } phase_t;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   field_index, field_index_next;
  logic [OFS_W-1:0]   record_offset, record_offset_next;
  logic [LEN_W-1:0]   record_size, record_size_next;
  logic [LEN_W-1:0]   run_count, run_count_next;
  logic [LEN_W-1:0]   idx_inc;

  assign idx_inc = field_index + LEN_W'(1);

  // Next-state and result decode
  always_comb begin
    phase_next         = phase;
    field_index_next   = field_index;
    record_offset_next = record_offset;
    record_size_next   = record_size;
    run_count_next     = run_count;
    res                = '0;

    unique case (phase)
      PH_HEADER: begin
        if (field_index > LEN_W'(HDR_LEN - 1) || byte_in != hdr_char(field_index[2:0])) begin
          phase_next = PH_ERROR;
          res.valid  = 1'b1;
          res.kind   = KIND_BADHDR;
        end else if (field_index == LEN_W'(HDR_LEN - 1)) begin
          phase_next         = PH_OFFSET;
          field_index_next   = '0;
          record_offset_next = '0;
        end else begin
          field_index_next = idx_inc;
        end
      end
      PH_OFFSET: begin
        record_offset_next = {record_offset[OFS_W-9:0], byte_in};
        field_index_next   = idx_inc;
        if (field_index >= LEN_W'(2)) begin
          field_index_next = '0;
          if (record_offset_next == EOF_MARK) begin
            phase_next = PH_ENDED;
            res.valid  = 1'b1;
            res.kind   = KIND_END;
          end else begin
            phase_next       = PH_SIZE;
            record_size_next = '0;
          end
        end
      end
      PH_SIZE: begin
        record_size_next = {record_size[LEN_W-9:0], byte_in};
        field_index_next = idx_inc;
        if (field_index >= LEN_W'(1)) begin
          field_index_next = '0;
          if (record_size_next == '0) begin
            phase_next     = PH_RUNCOUNT;
            run_count_next = '0;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res.valid        = 1'b1;
        res.kind         = KIND_WRITE;
        res.addr         = ADDR_W'(record_offset) + ADDR_W'(field_index);
        res.len          = LEN_W'(1);
        res.value        = byte_in;
        field_index_next = idx_inc;
        if (idx_inc >= record_size) begin
          phase_next         = PH_OFFSET;
          field_index_next   = '0;
          record_offset_next = '0;
        end
      end
      PH_RUNCOUNT: begin
        run_count_next   = {run_count[LEN_W-9:0], byte_in};
        field_index_next = idx_inc;
        if (field_index >= LEN_W'(1)) begin
          field_index_next = '0;
          phase_next       = PH_RUNVALUE;
        end
      end
      PH_RUNVALUE: begin
        res.valid          = 1'b1;
        res.kind           = KIND_FILL;
        res.addr           = ADDR_W'(record_offset);
        res.len            = run_count;
        res.value          = byte_in;
        phase_next         = PH_OFFSET;
        field_index_next   = '0;
        record_offset_next = '0;
      end
      default: begin
        // ended or errored: bytes are dropped
      end
    endcase

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      field_index   <= '0;
      record_offset <= '0;
      record_size   <= '0;
      run_count     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      field_index   <= field_index_next;
      record_offset <= record_offset_next;
      record_size   <= record_size_next;
      run_count     <= run_count_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ipsp_out_reg.sv
// ----------------------------------------------------------------------------
// ipsp_out_reg
// Result register that holds one word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsp_out_reg import ipsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ipsp_result_t      res,
  input  wire logic              stall,
  output logic                   free,
  output logic                   valid,
  output logic [1:0]             kind,
  output logic [ADDR_W-1:0]      target_address,
  output logic [LEN_W-1:0]       run_length,
  output logic [7:0]             fill_value
);

  // Room for a new word when empty or when the held word leaves now
  assign free = !valid || !stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= res.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (free && res.valid) begin
      kind           <= res.kind;
      target_address <= res.addr;
      run_length     <= res.len;
      fill_value     <= res.value;
    end
  end

endmodule

`default_nettype wire
